[hw/rtl/fnsw_pkg.sv]
// Shared types and constants for the first-negative sliding window block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package fnsw_pkg;

   // Largest window the queue is sized for.
   localparam int MAX_WINDOW = 1024;
   // Queue index and fill count widths.
   localparam int ADDR_W  = $clog2(MAX_WINDOW);
   localparam int COUNT_W = $clog2(MAX_WINDOW + 1);
   // Positions run modulo twice the largest window.
   localparam int POS_W   = $clog2(2 * MAX_WINDOW);
   // Fixed field widths.
   localparam int WORD_W  = 32;
   localparam int WIN_W   = 11;

   // Input word: one sample and its end-of-array flag.
   typedef struct packed {
      logic signed [WORD_W-1:0] sample;
      logic                     last_of_array;
   } req_word_type;

   // Result word.
   typedef struct packed {
      logic signed [WORD_W-1:0] first_negative;
      logic                     last_window;
   } rsp_word_type;

   // One queued negative sample and the position it arrived at.
   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic [POS_W-1:0]  position;
   } entry_type;

   // Commands from the tracker to the queue.
   typedef struct packed {
      logic      clear;
      logic      advance;
      logic      pop;
      logic      push;
      entry_type entry;
   } queue_cmd_type;

   // The queue's first three entries and its count.
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      entry_type          first;
      entry_type          second;
      entry_type          third;
   } queue_view_type;

endpackage

[hw/rtl/fnsw_queue.sv]
// Queue of negative samples with a look-ahead on its first three entries.
// Depends on fnsw_pkg. The store is a single-port-write, registered-read memory.
`timescale 1ns / 1ps

module fnsw_queue
   import fnsw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_cmd_type  cmd,
   output queue_view_type view
);

   entry_type          mem [MAX_WINDOW];

   logic [ADDR_W-1:0]  head_ff;
   logic [ADDR_W-1:0]  head_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] count_after_pop;
   logic [ADDR_W-1:0]  tail;
   logic [ADDR_W-1:0]  read_addr;

   entry_type          first_ff;
   entry_type          first_in;
   entry_type          second_ff;
   entry_type          second_in;
   entry_type          mem_rd_ff;
   entry_type          bypass_entry_ff;
   logic               bypass_ff;
   entry_type          third;

   // The third entry comes from memory unless it was pushed in the last step.
   assign third = bypass_ff ? bypass_entry_ff : mem_rd_ff;

   // Pointer arithmetic for this step.
   assign count_after_pop = count_ff - COUNT_W'(cmd.pop);
   assign head_in         = head_ff + ADDR_W'(cmd.pop);
   assign tail            = head_in + count_after_pop[ADDR_W-1:0];
   assign read_addr       = head_in + ADDR_W'(2);
   assign count_in        = count_after_pop + COUNT_W'(cmd.push);

   // Shift the look-ahead on a pop and drop a push into its slot if it lands there.
   always_comb begin
      first_in  = cmd.pop ? second_ff : first_ff;
      second_in = cmd.pop ? third : second_ff;
      if (cmd.push && (count_after_pop == COUNT_W'(0))) begin
         first_in = cmd.entry;
      end
      if (cmd.push && (count_after_pop == COUNT_W'(1))) begin
         second_in = cmd.entry;
      end
   end

   // Control state: head, count and the bypass flag.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         head_ff   <= '0;
         count_ff  <= '0;
         bypass_ff <= 1'b0;
      end else if (cmd.advance) begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         bypass_ff <= cmd.push && (count_after_pop == COUNT_W'(2));
      end
   end

   // Look-ahead payload registers.
   always_ff @(posedge clock) begin
      if (cmd.advance) begin
         first_ff        <= first_in;
         second_ff       <= second_in;
         bypass_entry_ff <= cmd.entry;
      end
   end

   // Queue memory: every push is written, the third entry is read ahead.
   always_ff @(posedge clock) begin
      if (cmd.advance && cmd.push) begin
         mem[tail] <= cmd.entry;
      end
      if (cmd.advance) begin
         mem_rd_ff <= mem[read_addr];
      end
   end

   assign view.count  = count_ff;
   assign view.first  = first_ff;
   assign view.second = second_ff;
   assign view.third  = third;

endmodule

[hw/rtl/fnsw_track.sv]
// Window tracking: window length register, sample position, fill count and
// the per-sample pop, push and result decisions. Depends on fnsw_pkg.
`timescale 1ns / 1ps

module fnsw_track
   import fnsw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [WIN_W-1:0] csr_wr_data,
   input  logic             advance,
   input  req_word_type     item,
   input  queue_view_type   view,
   output queue_cmd_type    cmd,
   output logic             emit,
   output rsp_word_type     result
);

   logic [WIN_W-1:0]   window_ff;
   logic [WIN_W-1:0]   window_in;
   logic [POS_W-1:0]   position_ff;
   logic [WIN_W-1:0]   fill_ff;
   logic [WIN_W-1:0]   fill_in;
   logic [POS_W-1:0]   age;
   logic               pop;
   logic               push;
   logic [COUNT_W-1:0] count_after_pop;

   // Window length as written, with zero taken as one and large values saturated.
   always_comb begin
      window_in = csr_wr_data;
      if (csr_wr_data == WIN_W'(0)) begin
         window_in = WIN_W'(1);
      end else if (csr_wr_data > WIN_W'(MAX_WINDOW)) begin
         window_in = WIN_W'(MAX_WINDOW);
      end
   end

   // Drop the oldest entry once its position has left the window.
   assign age             = position_ff - view.first.position;
   assign pop             = (view.count != COUNT_W'(0)) && (WIN_W'(age) >= window_ff);
   assign count_after_pop = view.count - COUNT_W'(pop);
   assign push            = item.sample[WORD_W-1] && (count_after_pop < COUNT_W'(MAX_WINDOW));

   // A result comes once the window is full, or at the end of the array.
   assign fill_in = (fill_ff < window_ff) ? fill_ff + WIN_W'(1) : fill_ff;
   assign emit    = (fill_in >= window_ff) || item.last_of_array;

   // Oldest negative after this step's pop and push.
   always_comb begin
      result.last_window = item.last_of_array;
      if (count_after_pop != COUNT_W'(0)) begin
         result.first_negative = pop ? view.second.value : view.first.value;
      end else if (push) begin
         result.first_negative = item.sample;
      end else begin
         result.first_negative = '0;
      end
   end

   // Queue command; a register write or the end of an array empties it.
   assign cmd.clear          = csr_wr_en || (advance && item.last_of_array);
   assign cmd.advance        = advance;
   assign cmd.pop            = pop;
   assign cmd.push           = push;
   assign cmd.entry.value    = item.sample;
   assign cmd.entry.position = position_ff;

   // Window register, position and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= WIN_W'(1);
         position_ff <= '0;
         fill_ff     <= '0;
      end else if (csr_wr_en) begin
         window_ff   <= window_in;
         position_ff <= '0;
         fill_ff     <= '0;
      end else if (advance) begin
         if (item.last_of_array) begin
            position_ff <= '0;
            fill_ff     <= '0;
         end else begin
            position_ff <= position_ff + POS_W'(1);
            fill_ff     <= fill_in;
         end
      end
   end

endmodule

[hw/rtl/first_negative_sliding_window.sv]
// Top level of the first-negative sliding window block: input and result
// registers around fnsw_track and fnsw_queue. Depends on fnsw_pkg.
`timescale 1ns / 1ps
//
//  Channel | Ports                          | Carries
//  --------+--------------------------------+-----------------------------------
//  input   | req_valid, req_ready, req_word | sample, last_of_array
//  result  | rsp_valid, rsp_ready, rsp_word | first_negative, last_window
//  config  | csr_wr_en, csr_wr_data         | window_length (11 bits)
//
//  One word is taken per cycle while the result register is not stalled; a
//  result is valid once registered, since the tracker and queue decide
//  between the input register and the result register.
//  The queue keeps its first three entries in registers so that a pop and a
//  push can happen in every advancing cycle next to the registered memory
//  read. Reset is synchronous and needs no clearing pass. A stalled result
//  register holds the word in the input register, which in turn drops req_ready.

module first_negative_sliding_window
   import fnsw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_word_type     req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_word_type     rsp_word,
   input  logic             csr_wr_en,
   input  logic [WIN_W-1:0] csr_wr_data
);

   logic           in_valid_ff;
   req_word_type   in_word_ff;
   logic           rsp_valid_ff;
   rsp_word_type   rsp_word_ff;
   logic           advance;
   logic           emit;
   rsp_word_type   result;
   queue_cmd_type  cmd;
   queue_view_type view;

   // The held word moves on whenever the result register is free or draining.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
   end

   // Window decisions and the queue.
   fnsw_track u_track (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .advance     (advance),
      .item        (in_word_ff),
      .view        (view),
      .cmd         (cmd),
      .emit        (emit),
      .result      (result)
   );

   fnsw_queue u_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .view  (view)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
